// ===== sv/bc1_bc3_block_decoder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// BC1/BC2/BC3 block decoder assertion macros
// Shared property shapes for the decoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BC1_BC3_BLOCK_DECODER_UNIT_ASSERT_SVH
`define BC1_BC3_BLOCK_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off during reset
`define BCD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bcd check failed: same-cycle implication");

// Next-cycle implication, clocked on i_clk, off during reset
`define BCD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bcd check failed: next-cycle implication");

`endif

// ===== sv/bcd_pkg.sv =====
// ----------------------------------------------------------------------------
// BC1/BC2/BC3 block decoder package
// Shared types, codes and sizes for the front, queue and back of the decoder.
// ----------------------------------------------------------------------------
package bcd_pkg;

    // Default number of classified blocks held between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [1:0] CFG_FORMAT = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    // Reset values of the size registers
    localparam logic [15:0] WIDTH_RESET  = 16'd4;
    localparam logic [15:0] HEIGHT_RESET = 16'd4;

    // Block format codes; the spare code decodes as BC1
    typedef enum logic [1:0] {
        FMT_BC1     = 2'd0,
        FMT_BC2     = 2'd1,
        FMT_BC3     = 2'd2,
        FMT_BC1_ALT = 2'd3
    } t_fmt;

    // One compressed block
    typedef struct packed {
        logic [63:0] alpha_word;
        logic [63:0] color_word;
    } t_in;

    // One decoded pixel
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic        last_of_block;
        logic        last_of_image;
    } t_out;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_rgba;

    // Classified block, ready for pixel emission
    typedef struct packed {
        t_rgba [3:0]      pal;
        logic [7:0][7:0]  apal;
        logic [63:0]      alpha_word;
        logic [31:0]      color_idx;
        t_fmt             fmt;
        logic [15:0]      x0;
        logic [15:0]      y0;
        logic [1:0]       last_col;
        logic [1:0]       last_row;
        logic             end_img;
    } t_blk;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== sv/bc1_bc3_block_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// BC1/BC2/BC3 block decoder unit
// Decodes compressed 4x4 blocks in raster block order into RGBA8 pixels with
// image coordinates, dropping pixels outside the configured image.
//
//   Channel   Direction  Handshake              Payload
//   input     in         i_valid / o_stall      i_data  (alpha_word, color_word)
//   output    out        o_valid / i_stall      o_data  (RGBA, x, y, last flags)
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One visible pixel leaves per cycle unless i_stall holds the output; a fully
// clipped block takes none. A block is classified in its accept cycle and
// pushed to the queue; its first pixel then enters the output register.
// Synchronous active-low reset empties the queue, zeroes the block position
// and sets format BC1, width 4, height 4. o_stall rises while QUEUE_DEPTH
// blocks wait; i_stall holds the output register and the walk.
// ----------------------------------------------------------------------------
module bc1_bc3_block_decoder_unit #(
    parameter int QUEUE_DEPTH = bcd_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  bcd_pkg::t_in   i_data,
    output logic           o_stall,
    output logic           o_valid,
    output bcd_pkg::t_out  o_data,
    input  logic           i_stall,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data
);

    logic            push;
    logic            pop;
    bcd_pkg::t_blk   push_data;
    bcd_pkg::t_blk   head;
    bcd_pkg::t_qstat q_status;

    // Classify blocks
    bcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // Decouple front and back
    bcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (q_status)
    );

    // Emit pixels
    bcd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_stall    (i_stall)
    );

endmodule

// ===== sv/bcd_front.sv =====
// ----------------------------------------------------------------------------
// BC1/BC2/BC3 block decoder front
// Holds the configuration and block position, builds the color and alpha
// palettes and the clip window of each block, and pushes it to the queue.
// ----------------------------------------------------------------------------
module bcd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  bcd_pkg::t_in        i_data,
    output logic                o_stall,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  bcd_pkg::t_qstat     i_q_status,
    output logic                o_push,
    output bcd_pkg::t_blk       o_push_data
);

    bcd_pkg::t_fmt r_fmt;
    logic [15:0]   r_width;
    logic [15:0]   r_height;
    logic [13:0]   r_col;
    logic [13:0]   r_row;

    logic          accept;
    logic          size_ok;
    logic [16:0]   w_sum;
    logic [16:0]   h_sum;
    logic [14:0]   col_inc;
    logic [14:0]   row_inc;
    logic          end_row;
    logic          end_img;
    logic [15:0]   x0;
    logic [15:0]   y0;
    logic [15:0]   rem_x;
    logic [15:0]   rem_y;
    logic          vis;
    logic [15:0]   c0;
    logic [15:0]   c1;
    logic          three_color;
    bcd_pkg::t_rgba e0;
    bcd_pkg::t_rgba e1;
    bcd_pkg::t_rgba [3:0] pal;
    logic [7:0][7:0] apal;
    logic [7:0]    a0;
    logic [7:0]    a1;

    // Expand 5- and 6-bit endpoint channels to 8 bits
    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic bcd_pkg::t_rgba unpack565(input logic [15:0] v);
        bcd_pkg::t_rgba p;
        p.r = widen5(v[15:11]);
        p.g = widen6(v[10:5]);
        p.b = widen5(v[4:0]);
        p.a = 8'd255;
        return p;
    endfunction

    // Floor division by small constants through reciprocal multiply
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] m;
        m = 20'(x) * 20'd683;
        return m[18:11];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [21:0] m;
        m = 22'(x) * 22'd1639;
        return m[20:13];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [21:0] m;
        m = 22'(x) * 22'd2341;
        return m[21:14];
    endfunction

    function automatic logic [7:0] mix2(input logic [7:0] p, input logic [7:0] q);
        logic [8:0] s;
        s = {1'b0, p} + {1'b0, q};
        return s[8:1];
    endfunction

    function automatic logic [7:0] mix3(input logic [7:0] p, input logic [7:0] q);
        logic [9:0] s;
        s = {1'b0, p, 1'b0} + {2'b00, q};
        return div3(s);
    endfunction

    // Configuration writes are always taken
    assign o_cfg_ready = 1'b1;
    assign o_stall     = i_q_status.full;

    // Position, end-of-row and clip window of the incoming block
    always_comb begin
        accept  = i_valid && !i_q_status.full;
        size_ok = (r_width != 16'd0) && (r_height != 16'd0);
        w_sum   = {1'b0, r_width} + 17'd3;
        h_sum   = {1'b0, r_height} + 17'd3;
        col_inc = {1'b0, r_col} + 15'd1;
        row_inc = {1'b0, r_row} + 15'd1;
        end_row = col_inc >= w_sum[16:2];
        end_img = end_row && (row_inc >= h_sum[16:2]);
        x0      = {r_col, 2'b00};
        y0      = {r_row, 2'b00};
        rem_x   = r_width - x0;
        rem_y   = r_height - y0;
        vis     = (x0 < r_width) && (y0 < r_height);
    end

    // Color palette
    always_comb begin
        c0          = i_data.color_word[15:0];
        c1          = i_data.color_word[31:16];
        three_color = (r_fmt == bcd_pkg::FMT_BC1 || r_fmt == bcd_pkg::FMT_BC1_ALT)
                      && (c0 <= c1);
        e0          = unpack565(c0);
        e1          = unpack565(c1);
        pal[0]      = e0;
        pal[1]      = e1;
        if (three_color) begin
            pal[2].r = mix2(e0.r, e1.r);
            pal[2].g = mix2(e0.g, e1.g);
            pal[2].b = mix2(e0.b, e1.b);
            pal[2].a = 8'd255;
            pal[3]   = '0;
        end else begin
            pal[2].r = mix3(e0.r, e1.r);
            pal[2].g = mix3(e0.g, e1.g);
            pal[2].b = mix3(e0.b, e1.b);
            pal[2].a = 8'd255;
            pal[3].r = mix3(e1.r, e0.r);
            pal[3].g = mix3(e1.g, e0.g);
            pal[3].b = mix3(e1.b, e0.b);
            pal[3].a = 8'd255;
        end
    end

    // Interpolated alpha palette: eight steps, or six plus zero and full
    always_comb begin
        a0      = i_data.alpha_word[7:0];
        a1      = i_data.alpha_word[15:8];
        apal    = '0;
        apal[0] = a0;
        apal[1] = a1;
        for (int k = 1; k <= 6; k++) begin
            if (a0 > a1) begin
                apal[k + 1] = div7(11'(7 - k) * {3'b000, a0} + 11'(k) * {3'b000, a1});
            end else if (k <= 4) begin
                apal[k + 1] = div5(11'(5 - k) * {3'b000, a0} + 11'(k) * {3'b000, a1});
            end else if (k == 5) begin
                apal[k + 1] = 8'd0;
            end else begin
                apal[k + 1] = 8'd255;
            end
        end
    end

    // Queue entry
    always_comb begin
        o_push                 = accept && size_ok && vis;
        o_push_data.pal        = pal;
        o_push_data.apal       = apal;
        o_push_data.alpha_word = i_data.alpha_word;
        o_push_data.color_idx  = i_data.color_word[63:32];
        o_push_data.fmt        = r_fmt;
        o_push_data.x0         = x0;
        o_push_data.y0         = y0;
        o_push_data.last_col   = (rem_x >= 16'd4) ? 2'd3 : (rem_x[1:0] - 2'd1);
        o_push_data.last_row   = (rem_y >= 16'd4) ? 2'd3 : (rem_y[1:0] - 2'd1);
        o_push_data.end_img    = end_img;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= bcd_pkg::FMT_BC1;
            r_width  <= bcd_pkg::WIDTH_RESET;
            r_height <= bcd_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bcd_pkg::CFG_FORMAT: r_fmt    <= bcd_pkg::t_fmt'(i_cfg_data[1:0]);
                bcd_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                bcd_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance block column and row; hold them while the image is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept && size_ok) begin
            if (end_row) begin
                r_col <= '0;
                r_row <= end_img ? 14'd0 : row_inc[13:0];
            end else begin
                r_col <= col_inc[13:0];
            end
        end
    end

endmodule

// ===== sv/bcd_queue.sv =====
// ----------------------------------------------------------------------------
// BC1/BC2/BC3 block decoder queue
// Short first-in first-out store of classified blocks (DEPTH of 2 or more).
// ----------------------------------------------------------------------------
module bcd_queue #(
    parameter int DEPTH = bcd_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bcd_pkg::t_blk   i_push_data,
    input  logic            i_pop,
    output bcd_pkg::t_blk   o_head,
    output bcd_pkg::t_qstat o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bcd_pkg::t_blk    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_count;

    // Wrap pointers and track fill level
    always_comb begin
        n_wr    = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        n_rd    = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            r_count <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

// ===== sv/bcd_back.sv =====
// ----------------------------------------------------------------------------
// BC1/BC2/BC3 block decoder back
// Walks the head block's visible pixels, one per cycle unless stalled, picks
// color and alpha from the palettes and drives the registered pixel output.
// ----------------------------------------------------------------------------
`include "bc1_bc3_block_decoder_unit_assert.svh"

module bcd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bcd_pkg::t_blk   i_head,
    input  bcd_pkg::t_qstat i_q_status,
    output logic            o_pop,
    output logic            o_valid,
    output bcd_pkg::t_out   o_data,
    input  logic            i_stall
);

    logic [1:0]     r_px;
    logic [1:0]     r_py;
    logic           r_out_valid;
    bcd_pkg::t_out  r_out;

    logic           head_valid;
    logic           advance;
    logic           last_pix;
    logic [3:0]     pix;
    logic [1:0]     ci;
    logic [3:0]     nib;
    logic [5:0]     abit;
    logic [2:0]     ai;
    bcd_pkg::t_rgba p;
    logic [7:0]     alpha;
    bcd_pkg::t_out  n_out;

    // Select the pixel under the counters
    always_comb begin
        head_valid = !i_q_status.empty;
        advance    = head_valid && (!r_out_valid || !i_stall);
        last_pix   = (r_px == i_head.last_col) && (r_py == i_head.last_row);
        pix        = {r_py, r_px};
        ci         = i_head.color_idx[{pix, 1'b0} +: 2];
        p          = i_head.pal[ci];
        nib        = i_head.alpha_word[{pix, 2'b00} +: 4];
        abit       = 6'd16 + {2'b00, pix} * 6'd3;
        ai         = i_head.alpha_word[abit +: 3];
        unique case (i_head.fmt)
            bcd_pkg::FMT_BC2:     alpha = {nib, nib};
            bcd_pkg::FMT_BC3:     alpha = i_head.apal[ai];
            bcd_pkg::FMT_BC1,
            bcd_pkg::FMT_BC1_ALT: alpha = p.a;
        endcase
        n_out.red           = p.r;
        n_out.green         = p.g;
        n_out.blue          = p.b;
        n_out.alpha         = alpha;
        n_out.pixel_x       = i_head.x0 + {14'd0, r_px};
        n_out.pixel_y       = i_head.y0 + {14'd0, r_py};
        n_out.last_of_block = last_pix;
        n_out.last_of_image = last_pix && i_head.end_img;
        o_pop               = advance && last_pix;
    end

    // Step through columns, then rows, of the visible window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
            r_py <= '0;
        end else if (advance) begin
            if (last_pix) begin
                r_px <= '0;
                r_py <= '0;
            end else if (r_px == i_head.last_col) begin
                r_px <= '0;
                r_py <= r_py + 2'd1;
            end else begin
                r_px <= r_px + 2'd1;
            end
        end
    end

    // Output register: load on advance, drop once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `BCD_ASSERT_IMP(a_pop_on_last, o_pop, head_valid && last_pix)
    `BCD_ASSERT_NEXT(a_pop_rewinds, o_pop, r_px == 2'd0 && r_py == 2'd0)
    `BCD_ASSERT_IMP(a_img_end_is_blk_end, r_out_valid && r_out.last_of_image, r_out.last_of_block)
    `BCD_ASSERT_IMP(a_pix_in_window, head_valid, r_px <= i_head.last_col && r_py <= i_head.last_row)

endmodule
